@@ design/trs_pkg.sv @@
// Package for the tagged record search block.
// Holds the parse phases, result status codes, register indexes and tag constants.
// No dependencies.
`default_nettype none

package trs_pkg;

  localparam int AREA_BYTES = 4096;
  localparam int OFF_W      = 17;
  localparam int NEXT_W     = OFF_W + 1;

  localparam logic [31:0] TAG_HEAD = 32'h4441_4548;
  localparam logic [31:0] TAG_CHKS = 32'h5348_4B43;

  localparam logic [NEXT_W-1:0] AREA_END = NEXT_W'(AREA_BYTES);

  typedef enum logic [0:0] {
    REG_WANTED_ID   = 1'b0,
    REG_WANTED_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_IDENT  = 3'd2,
    PH_LENGTH = 3'd3,
    PH_COPY   = 3'd4,
    PH_SKIP   = 3'd5,
    PH_PAD    = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA          = 3'd0,
    ST_FOUND         = 3'd1,
    ST_NO_HEADER     = 3'd2,
    ST_SIZE_MISMATCH = 3'd3,
    ST_CHECKSUM      = 3'd4,
    ST_END_AREA      = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ design/tagged_record_search_core.sv @@
// Tagged record search core: walks a tagged configuration image byte by byte and
// returns the data of the wanted record. Depends on trs_pkg.
//
// The block takes one image byte per clock cycle while in_stall is low and gives
// at most one result per byte. Each accepted byte updates the offset, tag, length
// and down counters, and its result goes into the output register, backed by a
// one-entry skid stage, so a stalled consumer does not stall the input until both
// are full. A byte with in_image_start high restarts the search in any phase;
// bytes that arrive before a start or after the search has ended are consumed
// without a result. Write wanted_id and wanted_size only while no transaction is
// in flight.
`default_nettype none

module tagged_record_search_core
  import trs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_image_byte,
  input  wire logic        in_image_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_data_byte,
  output logic             out_last
);

  logic [31:0]      wanted_id_r;
  logic [14:0]      wanted_size_r;

  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic [31:0]      ident_r, ident_nxt;
  logic [15:0]      length_r, length_nxt;
  logic [15:0]      left_r, left_nxt;

  logic             out_vld_r;
  result_t          out_r;
  logic             skid_vld_r;
  result_t          skid_r;

  logic             accept;
  logic             out_free;
  logic             res_vld;
  result_t          res;

  phase_t           cur_phase;
  logic [OFF_W-1:0] cur_off;
  logic [31:0]      cur_ident;
  logic [15:0]      cur_len;
  logic [15:0]      cur_left;
  logic [NEXT_W-1:0] next_off;
  logic [3:0]       lo;
  logic             next_aligned;
  logic             end_hit;
  logic [31:0]      byte_shift;
  logic [31:0]      ident_or;
  logic [15:0]      len_low;
  logic [15:0]      left_dec;

  assign in_stall = skid_vld_r;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_id_r   <= '0;
      wanted_size_r <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_WANTED_ID:   wanted_id_r   <= cfg_data;
        REG_WANTED_SIZE: wanted_size_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_phase = in_image_start ? PH_HEADER : phase_r;
    cur_off   = in_image_start ? '0 : offset_r;
    cur_ident = in_image_start ? '0 : ident_r;
    cur_len   = in_image_start ? '0 : length_r;
    cur_left  = in_image_start ? '0 : left_r;

    next_off     = {1'b0, cur_off} + NEXT_W'(1);
    lo           = cur_off[3:0];
    next_aligned = (next_off[3:0] == 4'd0);
    end_hit      = (next_off >= AREA_END);
    byte_shift   = {24'd0, in_image_byte} << {lo[1:0], 3'b000};
    ident_or     = cur_ident | byte_shift;
    len_low      = {cur_len[15:8], in_image_byte};
    left_dec     = cur_left - 16'd1;

    phase_nxt  = cur_phase;
    offset_nxt = cur_off;
    ident_nxt  = cur_ident;
    length_nxt = cur_len;
    left_nxt   = cur_left;
    res_vld    = 1'b0;
    res        = '{status: ST_DATA, data_byte: 8'd0, last: 1'b0};

    case (cur_phase)
      PH_HEADER: begin
        if (lo < 4'd4) begin
          ident_nxt = ident_or;
        end
        if (lo == 4'd3 && ident_or != TAG_HEAD) begin
          res_vld = 1'b1;
          res     = '{status: ST_NO_HEADER, data_byte: 8'd0, last: 1'b1};
        end else if (lo == 4'd15) begin
          if (end_hit) begin
            res_vld = 1'b1;
            res     = '{status: ST_END_AREA, data_byte: 8'd0, last: 1'b1};
          end else begin
            offset_nxt = next_off[OFF_W-1:0];
            ident_nxt  = '0;
            phase_nxt  = PH_IDENT;
          end
        end else begin
          offset_nxt = next_off[OFF_W-1:0];
        end
      end
      PH_IDENT: begin
        ident_nxt  = ident_or;
        offset_nxt = next_off[OFF_W-1:0];
        if (lo[1:0] == 2'd3) begin
          if (ident_or != wanted_id_r && ident_or == TAG_CHKS) begin
            res_vld = 1'b1;
            res     = '{status: ST_CHECKSUM, data_byte: 8'd0, last: 1'b1};
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        offset_nxt = next_off[OFF_W-1:0];
        if (lo == 4'd4) begin
          length_nxt = {in_image_byte, 8'd0};
        end else begin
          length_nxt = len_low;
          if (cur_ident == wanted_id_r) begin
            if (len_low != {1'b0, wanted_size_r}) begin
              res_vld = 1'b1;
              res     = '{status: ST_SIZE_MISMATCH, data_byte: 8'd0, last: 1'b1};
            end else if (len_low == 16'd0) begin
              res_vld = 1'b1;
              res     = '{status: ST_FOUND, data_byte: 8'd0, last: 1'b1};
            end else begin
              left_nxt  = len_low;
              phase_nxt = PH_COPY;
            end
          end else if (len_low == 16'd0) begin
            phase_nxt = PH_PAD;
          end else begin
            left_nxt  = len_low;
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_COPY: begin
        offset_nxt = next_off[OFF_W-1:0];
        left_nxt   = left_dec;
        res_vld    = 1'b1;
        if (left_dec == 16'd0) begin
          res = '{status: ST_FOUND, data_byte: in_image_byte, last: 1'b1};
        end else begin
          res = '{status: ST_DATA, data_byte: in_image_byte, last: 1'b0};
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == 16'd0 && next_aligned) begin
          if (end_hit) begin
            res_vld = 1'b1;
            res     = '{status: ST_END_AREA, data_byte: 8'd0, last: 1'b1};
          end else begin
            offset_nxt = next_off[OFF_W-1:0];
            ident_nxt  = '0;
            phase_nxt  = PH_IDENT;
          end
        end else begin
          offset_nxt = next_off[OFF_W-1:0];
          if (left_dec == 16'd0) begin
            phase_nxt = PH_PAD;
          end
        end
      end
      PH_PAD: begin
        if (next_aligned) begin
          if (end_hit) begin
            res_vld = 1'b1;
            res     = '{status: ST_END_AREA, data_byte: 8'd0, last: 1'b1};
          end else begin
            offset_nxt = next_off[OFF_W-1:0];
            ident_nxt  = '0;
            phase_nxt  = PH_IDENT;
          end
        end else begin
          offset_nxt = next_off[OFF_W-1:0];
        end
      end
      default: ;
    endcase

    if (res_vld && res.last) begin
      phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      offset_r <= '0;
      ident_r  <= '0;
      length_r <= '0;
      left_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      ident_r  <= ident_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
    end
  end

  // Drain skid first to keep transaction order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= accept && res_vld;
      end
    end else if (accept && res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (accept && res_vld) begin
      skid_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_r.status;
  assign out_data_byte = out_r.data_byte;
  assign out_last      = out_r.last;

endmodule

`default_nettype wire

@@ design/trs_checker.sv @@
// Port-level checker for tagged_record_search_core, with its bind statement.
// Depends on trs_pkg.
`default_nettype none

module trs_checker
  import trs_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_last
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_data_byte) && $stable(out_last))
    else $error("stalled result transaction changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_END_AREA)
    else $error("status code out of range");

  a_last_vs_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_DATA) != out_last))
    else $error("last flag disagrees with status");

  a_status_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA && out_status != ST_FOUND
      |-> out_data_byte == 8'd0)
    else $error("status-only result carries data");

endmodule

bind tagged_record_search_core trs_checker u_trs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_data_byte (out_data_byte),
  .out_last      (out_last)
);

`default_nettype wire

@@ tb/trs_checker.sv @@
`timescale 1ns / 1ps
// Checker for the tagged record search core: tracks register writes, predicts the
// result of every accepted image byte and compares it with the result channel.
// Depends on trs_pkg.
module trs_tb_checker
  import trs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_image_byte,
  input  logic        in_image_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_data_byte,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  logic [31:0] wanted_id;
  logic [14:0] wanted_size;

  phase_t      parse_phase;
  logic [16:0] offset;
  logic [31:0] ident;
  logic [15:0] rec_len;
  logic [15:0] remaining;

  result_t     expected_results[$];

  function automatic bit close_search(input status_t st, input logic [7:0] data,
                                      output result_t r);
    r.status    = st;
    r.data_byte = data;
    r.last      = 1'b1;
    parse_phase = PH_DONE;
    return 1'b1;
  endfunction

  function automatic bit next_record(input logic [NEXT_W-1:0] nxt, output result_t r);
    r = '0;
    if (nxt >= AREA_END) begin
      return close_search(ST_END_AREA, 8'h00, r);
    end
    offset      = nxt[OFF_W-1:0];
    ident       = '0;
    parse_phase = PH_IDENT;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic st, output result_t r);
    logic [NEXT_W-1:0] nxt;
    logic [3:0]        lo;
    r = '0;
    if (st) begin
      parse_phase = PH_HEADER;
      offset      = '0;
      ident       = '0;
      rec_len     = '0;
      remaining   = '0;
    end else if (parse_phase == PH_IDLE || parse_phase == PH_DONE) begin
      return 1'b0;
    end
    nxt = {1'b0, offset} + 1'b1;
    lo  = offset[3:0];
    case (parse_phase)
      PH_HEADER: begin
        if (lo < 4'd4) ident[{lo[1:0], 3'b000} +: 8] = b;
        if (lo == 4'd3 && ident != TAG_HEAD) return close_search(ST_NO_HEADER, 8'h00, r);
        if (lo == 4'd15) return next_record(nxt, r);
        offset = nxt[OFF_W-1:0];
        return 1'b0;
      end
      PH_IDENT: begin
        ident[{lo[1:0], 3'b000} +: 8] = b;
        offset = nxt[OFF_W-1:0];
        if (lo[1:0] == 2'd3) begin
          if (ident != wanted_id && ident == TAG_CHKS)
            return close_search(ST_CHECKSUM, 8'h00, r);
          parse_phase = PH_LENGTH;
        end
        return 1'b0;
      end
      PH_LENGTH: begin
        offset = nxt[OFF_W-1:0];
        if (lo == 4'd4) begin
          rec_len = {b, 8'h00};
          return 1'b0;
        end
        rec_len[7:0] = b;
        if (ident == wanted_id) begin
          if (rec_len != {1'b0, wanted_size}) return close_search(ST_SIZE_MISMATCH, 8'h00, r);
          if (rec_len == 16'd0) return close_search(ST_FOUND, 8'h00, r);
          remaining   = rec_len;
          parse_phase = PH_COPY;
        end else if (rec_len == 16'd0) begin
          parse_phase = PH_PAD;
        end else begin
          remaining   = rec_len;
          parse_phase = PH_SKIP;
        end
        return 1'b0;
      end
      PH_COPY: begin
        offset    = nxt[OFF_W-1:0];
        remaining = remaining - 1'b1;
        if (remaining == 16'd0) return close_search(ST_FOUND, b, r);
        r.status    = ST_DATA;
        r.data_byte = b;
        r.last      = 1'b0;
        return 1'b1;
      end
      PH_SKIP: begin
        remaining = remaining - 1'b1;
        if (remaining == 16'd0) begin
          if (nxt[3:0] == 4'd0) return next_record(nxt, r);
          parse_phase = PH_PAD;
        end
        offset = nxt[OFF_W-1:0];
        return 1'b0;
      end
      PH_PAD: begin
        if (nxt[3:0] == 4'd0) return next_record(nxt, r);
        offset = nxt[OFF_W-1:0];
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic log_failure(input string what, input result_t exp, input result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected status %0d data %02h last %0b, got status %0d data %02h last %0b",
               $realtime, what, exp.status, exp.data_byte, exp.last,
               got.status, got.data_byte, got.last);
  endtask

  always @(posedge clk) begin
    result_t predicted;
    result_t got;
    result_t exp;
    if (!rst_n) begin
      wanted_id   = '0;
      wanted_size = '0;
      parse_phase = PH_IDLE;
      offset      = '0;
      ident       = '0;
      rec_len     = '0;
      remaining   = '0;
      expected_results.delete();
      pending     = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_WANTED_ID:   wanted_id = cfg_data;
          REG_WANTED_SIZE: wanted_size = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_image_byte, in_image_start, predicted))
          expected_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        got.status    = status_t'(out_status);
        got.data_byte = out_data_byte;
        got.last      = out_last;
        if (expected_results.size() == 0) begin
          log_failure("unexpected transaction", '0, got);
        end else begin
          exp = expected_results.pop_front();
          if (got.status !== exp.status || got.data_byte !== exp.data_byte ||
              got.last !== exp.last)
            log_failure("result mismatch", exp, got);
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

@@ tb/tagged_record_search_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for tagged_record_search_core: drives image bytes and register writes
// under random idling and gives the verdict. Depends on it, trs_pkg and trs_tb_checker.
module tagged_record_search_core_tb;
  import trs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_image_byte = '0;
  logic        in_image_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_data_byte;
  logic        out_last;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent = 0;
  logic [31:0] want_id = '0;
  logic [14:0] want_size = '0;

  tagged_record_search_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_image_byte(in_image_byte), .in_image_start(in_image_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_data_byte(out_data_byte), .out_last(out_last)
  );

  trs_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_image_byte(in_image_byte), .in_image_start(in_image_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_data_byte(out_data_byte), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_image_byte(input logic [7:0] b, input logic st);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_image_byte  <= b;
    in_image_start <= st;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // drop valid and wait out every result still owed
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] id, input logic [14:0] size);
    settle();
    write_reg(REG_WANTED_ID, id);
    write_reg(REG_WANTED_SIZE, {17'd0, size});
    want_id   = id;
    want_size = size;
  endtask

  task automatic send_header(input bit corrupt);
    logic [31:0] tag;
    tag = TAG_HEAD;
    if (corrupt) tag[$urandom_range(31, 0)] ^= 1'b1;
    for (int i = 0; i < 4; i++) send_image_byte(tag[8*i +: 8], i == 0);
    repeat (12) send_image_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_record(input logic [31:0] id, input logic [15:0] len,
                             input bit allow_cut, output bit cut);
    logic [7:0] rec_bytes[$];
    int         n;
    int         keep;
    for (int i = 0; i < 4; i++) rec_bytes.push_back(id[8*i +: 8]);
    rec_bytes.push_back(len[15:8]);
    rec_bytes.push_back(len[7:0]);
    cut = (len > 16'd64);
    n = cut ? $urandom_range(20, 1) : int'(len);
    repeat (n) rec_bytes.push_back(8'($urandom));
    if (!cut) while ((rec_bytes.size() % 16) != 0) rec_bytes.push_back(8'($urandom));
    keep = rec_bytes.size();
    if (allow_cut && $urandom_range(99) < 4) begin
      keep = $urandom_range(rec_bytes.size(), 1);
      cut  = 1'b1;
    end
    for (int i = 0; i < keep; i++) send_image_byte(rec_bytes[i], 1'b0);
  endtask

  function automatic logic [31:0] pick_ident();
    int r;
    r = $urandom_range(99);
    if (r < 30) return want_id;
    if (r < 40) return TAG_CHKS;
    if (r < 45) return TAG_HEAD;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_length(input logic [31:0] id);
    int r;
    r = $urandom_range(99);
    if (id == want_id && r < 75) return {1'b0, want_size};
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(40, 0));
    if (r < 80) return 16'd0;
    if (r < 90) return 16'($urandom_range(16'h0128, 16'h0100));
    if (r < 95) return 16'hFFFF;
    return 16'($urandom_range(65535, 65));
  endfunction

  task automatic send_image();
    logic [31:0] id;
    bit          cut;
    if ($urandom_range(99) < 5) repeat ($urandom_range(3, 1)) send_image_byte(8'($urandom), 1'b0);
    if ($urandom_range(99) < 10) begin
      send_header(1'b1);
      return;
    end
    send_header(1'b0);
    repeat ($urandom_range(6, 1)) begin
      id = pick_ident();
      send_record(id, pick_length(id), 1'b1, cut);
      if (cut || id == want_id || id == TAG_CHKS) break;
    end
  endtask

  task automatic reconfigure();
    logic [31:0] id;
    logic [14:0] size;
    int          r;
    r = $urandom_range(99);
    id = (r < 70) ? $urandom : (r < 80) ? TAG_CHKS : (r < 90) ? 32'd0 : 32'hFFFF_FFFF;
    r = $urandom_range(99);
    size = (r < 60) ? 15'($urandom_range(24, 0)) : (r < 75) ? 15'd0 :
           (r < 85) ? 15'h7FFF : 15'($urandom);
    configure(id, size);
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct, input int budget);
    int target;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    target = bytes_sent + budget;
    while (bytes_sent < target) begin
      if ($urandom_range(3) == 0) reconfigure();
      send_image();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    configure(32'hFFFF_FFFF, 15'h7FFF);
    send_image_byte(8'hFF, 1'b0);
    send_image_byte(8'h00, 1'b1);
    send_image_byte(8'h45, 1'b0);
    send_image_byte(8'h41, 1'b0);
    send_image_byte(8'hFF, 1'b0);
    send_image_byte(8'h48, 1'b0);
    send_image_byte(8'h48, 1'b1);
    send_image_byte(8'h45, 1'b0);
    send_image_byte(8'h41, 1'b0);
    send_image_byte(8'h44, 1'b0);
    for (int i = 0; i < 12; i++) send_image_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
    repeat (4) send_image_byte(8'hFF, 1'b0);
    send_image_byte(8'h7F, 1'b0);
    send_image_byte(8'hFF, 1'b0);
    send_image_byte(8'h00, 1'b0);
    send_image_byte(8'hFF, 1'b0);

    run_phase(18, 84, 580);
    run_phase(84, 18, 580);
    run_phase(0, 0, 580);
    settle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/trs_pkg.sv
design/tagged_record_search_core.sv
design/trs_checker.sv
tb/trs_checker.sv
tb/tagged_record_search_core_tb.sv
